[sv/sequential_list_engine_top_macros.svh]
// Assertion macros shared by the list engine RTL
`ifndef SEQUENTIAL_LIST_ENGINE_TOP_MACROS_SVH
`define SEQUENTIAL_LIST_ENGINE_TOP_MACROS_SVH

// check a condition in the same cycle
`define SLE_AST_IMPL(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("list engine check failed");

// check a condition in the following cycle
`define SLE_AST_NEXT(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("list engine check failed");

`endif

[sv/sle_pkg.sv]
// Types, codes and microcode table of the list engine
`default_nettype none

package sle_pkg;

	localparam int OpW     = 3;
	localparam int PosW    = 10;
	localparam int ValW    = 31;
	localparam int CntOutW = 11;
	localparam int LimW    = 11;
	localparam int PcW     = 5;

	localparam logic [LimW-1:0] LIMIT_RESET = 11'd1024;

	localparam logic [OpW-1:0] OP_CLEAR   = 3'd0;
	localparam logic [OpW-1:0] OP_INSERT  = 3'd1;
	localparam logic [OpW-1:0] OP_DELETE  = 3'd2;
	localparam logic [OpW-1:0] OP_READ    = 3'd3;
	localparam logic [OpW-1:0] OP_REVERSE = 3'd4;

	typedef struct packed {
		logic [OpW-1:0]  op;
		logic [PosW-1:0] position;
		logic [ValW-1:0] value;
	} in_item_t;

	typedef struct packed {
		logic               ok;
		logic [ValW-1:0]    read_value;
		logic [CntOutW-1:0] count;
	} out_item_t;

	localparam logic [2:0] RD_NONE   = 3'd0;
	localparam logic [2:0] RD_IDX    = 3'd1;
	localparam logic [2:0] RD_IDX_M1 = 3'd2;
	localparam logic [2:0] RD_IDX_P1 = 3'd3;
	localparam logic [2:0] RD_HI     = 3'd4;
	localparam logic [2:0] RD_POS    = 3'd5;

	localparam logic [1:0] WA_IDX = 2'd0;
	localparam logic [1:0] WA_HI  = 2'd1;
	localparam logic [1:0] WA_CNT = 2'd2;

	localparam logic [1:0] WD_RDATA = 2'd0;
	localparam logic [1:0] WD_TMP   = 2'd1;
	localparam logic [1:0] WD_VAL   = 2'd2;

	localparam logic [2:0] IX_HOLD = 3'd0;
	localparam logic [2:0] IX_CNT  = 3'd1;
	localparam logic [2:0] IX_POS  = 3'd2;
	localparam logic [2:0] IX_ZERO = 3'd3;
	localparam logic [2:0] IX_INC  = 3'd4;
	localparam logic [2:0] IX_DEC  = 3'd5;

	localparam logic [1:0] HI_HOLD  = 2'd0;
	localparam logic [1:0] HI_CNTM1 = 2'd1;
	localparam logic [1:0] HI_DEC   = 2'd2;

	localparam logic [1:0] CN_HOLD = 2'd0;
	localparam logic [1:0] CN_CLR  = 2'd1;
	localparam logic [1:0] CN_INC  = 2'd2;
	localparam logic [1:0] CN_DEC  = 2'd3;

	localparam logic [2:0] JC_NEVER    = 3'd0;
	localparam logic [2:0] JC_INS_MORE = 3'd1;
	localparam logic [2:0] JC_DEL_END  = 3'd2;
	localparam logic [2:0] JC_DEL_MORE = 3'd3;
	localparam logic [2:0] JC_REV_MORE = 3'd4;

	localparam logic [PcW-1:0] ST_REV0 = 5'd0;
	localparam logic [PcW-1:0] ST_REV1 = 5'd1;
	localparam logic [PcW-1:0] ST_REV2 = 5'd2;
	localparam logic [PcW-1:0] ST_REV3 = 5'd3;
	localparam logic [PcW-1:0] ST_REV4 = 5'd4;
	localparam logic [PcW-1:0] ST_FIN  = 5'd5;
	localparam logic [PcW-1:0] ST_CLR  = 5'd6;
	localparam logic [PcW-1:0] ST_APP  = 5'd7;
	localparam logic [PcW-1:0] ST_INS0 = 5'd8;
	localparam logic [PcW-1:0] ST_INS1 = 5'd9;
	localparam logic [PcW-1:0] ST_INS2 = 5'd10;
	localparam logic [PcW-1:0] ST_INS3 = 5'd11;
	localparam logic [PcW-1:0] ST_DEL0 = 5'd12;
	localparam logic [PcW-1:0] ST_DEL1 = 5'd13;
	localparam logic [PcW-1:0] ST_DEL2 = 5'd14;
	localparam logic [PcW-1:0] ST_DEL3 = 5'd15;
	localparam logic [PcW-1:0] ST_RD0  = 5'd16;
	localparam logic [PcW-1:0] ST_RD1  = 5'd17;

	typedef struct packed {
		logic [2:0]     rd_sel;
		logic           wr_en;
		logic [1:0]     wa_sel;
		logic [1:0]     wd_sel;
		logic           tmp_ld;
		logic [2:0]     idx_op;
		logic [1:0]     hi_op;
		logic [1:0]     cnt_op;
		logic           rd_cap;
		logic [2:0]     jc;
		logic [PcW-1:0] tgt;
		logic           fin;
	} uword_t;

	function automatic uword_t ucode(input logic [PcW-1:0] pc);
		uword_t w;
		w = '0;
		case (pc)
			ST_REV0: begin
				w.idx_op = IX_ZERO;
				w.hi_op  = HI_CNTM1;
			end
			ST_REV1: begin
				w.rd_sel = RD_IDX;
			end
			ST_REV2: begin
				w.rd_sel = RD_HI;
				w.tmp_ld = 1'b1;
			end
			ST_REV3: begin
				w.wr_en  = 1'b1;
				w.wa_sel = WA_IDX;
				w.wd_sel = WD_RDATA;
			end
			ST_REV4: begin
				w.wr_en  = 1'b1;
				w.wa_sel = WA_HI;
				w.wd_sel = WD_TMP;
				w.idx_op = IX_INC;
				w.hi_op  = HI_DEC;
				w.jc     = JC_REV_MORE;
				w.tgt    = ST_REV1;
			end
			ST_FIN: begin
				w.fin = 1'b1;
			end
			ST_CLR: begin
				w.cnt_op = CN_CLR;
				w.fin    = 1'b1;
			end
			ST_APP: begin
				w.wr_en  = 1'b1;
				w.wa_sel = WA_CNT;
				w.wd_sel = WD_VAL;
				w.cnt_op = CN_INC;
				w.fin    = 1'b1;
			end
			ST_INS0: begin
				w.idx_op = IX_CNT;
			end
			ST_INS1: begin
				w.rd_sel = RD_IDX_M1;
			end
			ST_INS2: begin
				w.wr_en  = 1'b1;
				w.wa_sel = WA_IDX;
				w.wd_sel = WD_RDATA;
				w.idx_op = IX_DEC;
				w.jc     = JC_INS_MORE;
				w.tgt    = ST_INS1;
			end
			ST_INS3: begin
				w.wr_en  = 1'b1;
				w.wa_sel = WA_IDX;
				w.wd_sel = WD_VAL;
				w.cnt_op = CN_INC;
				w.fin    = 1'b1;
			end
			ST_DEL0: begin
				w.idx_op = IX_POS;
				w.jc     = JC_DEL_END;
				w.tgt    = ST_DEL3;
			end
			ST_DEL1: begin
				w.rd_sel = RD_IDX_P1;
			end
			ST_DEL2: begin
				w.wr_en  = 1'b1;
				w.wa_sel = WA_IDX;
				w.wd_sel = WD_RDATA;
				w.idx_op = IX_INC;
				w.jc     = JC_DEL_MORE;
				w.tgt    = ST_DEL1;
			end
			ST_DEL3: begin
				w.cnt_op = CN_DEC;
				w.fin    = 1'b1;
			end
			ST_RD0: begin
				w.rd_sel = RD_POS;
			end
			ST_RD1: begin
				w.rd_cap = 1'b1;
				w.fin    = 1'b1;
			end
			default: begin
				w.fin = 1'b1;
			end
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

[sv/sle_ram.sv]
// Generic single-write, single-read RAM with registered read data
`default_nettype none

module sle_ram #(
	parameter int WIDTH = 31,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

[sv/sequential_list_engine_top.sv]
// Top level of the list engine: microcoded sequencer over one list RAM
// Usage:
//   in channel (in_valid, in_stall, in_data) takes one command: clear, insert,
//   delete, read or reverse, with position and value. out channel (out_valid,
//   out_stall, out_data) returns one result per command: ok, read_value, count.
//   cfg channel (cfg_valid, cfg_ready, cfg_data) writes list_limit; write it idle.
// Timing:
//   One command at a time; in_stall is high while a command runs. Clear,
//   append, rejected commands, reads past the count and reverse of fewer
//   than two entries finish in their entry step. A stored entry is read,
//   then captured; insert before the tail copies each word from the tail
//   down to position one place up, then writes the value; delete copies
//   each word above position one place down; reverse swaps pairs inward.
//   The result is valid the cycle after the last step and the next command
//   is taken at the following edge. Each moved word takes a read step and
//   a write step, as the RAM has one read port and one write port.
// Reset and stalls:
//   Reset empties the list (count zero, no clearing pass) and sets list_limit
//   to 1024. While out_stall holds a result, the next command is still taken
//   and runs up to its last step, where it waits for the output register.
`default_nettype none
`include "sequential_list_engine_top_macros.svh"

module sequential_list_engine_top #(
	parameter int CAPACITY = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  sle_pkg::in_item_t             in_data,
	output logic                          out_valid,
	input  logic                          out_stall,
	output sle_pkg::out_item_t            out_data,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [sle_pkg::LimW-1:0]      cfg_data
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int KW = (CW > sle_pkg::LimW) ? CW : sle_pkg::LimW;
	localparam logic [KW-1:0] CAP_K = KW'(CAPACITY);

	logic                         busy_q;
	logic [sle_pkg::PcW-1:0]      pc_q;
	logic [sle_pkg::PcW-1:0]      pc_next;
	logic [sle_pkg::PcW-1:0]      entry_pc;
	logic                         entry_ok;
	sle_pkg::uword_t              uw;
	logic                         step_go;
	logic                         out_free;
	logic                         jump;
	logic [CW-1:0]                cnt_q;
	logic [CW-1:0]                cnt_next;
	logic [sle_pkg::LimW-1:0]     limit_q;
	logic [AW-1:0]                idx_q;
	logic [AW-1:0]                hi_q;
	logic [sle_pkg::PosW-1:0]     pos_q;
	logic [sle_pkg::ValW-1:0]     val_q;
	logic [sle_pkg::ValW-1:0]     tmp_q;
	logic                         ok_q;
	logic                         out_valid_q;
	sle_pkg::out_item_t           out_q;
	logic [KW-1:0]                pos_k;
	logic [KW-1:0]                in_pos_k;
	logic [KW-1:0]                cnt_k;
	logic [KW-1:0]                idx_k;
	logic [KW-1:0]                hi_k;
	logic [KW-1:0]                limit_k;
	logic [KW-1:0]                lim_k;
	logic                         ram_we;
	logic                         ram_re;
	logic [AW-1:0]                ram_waddr;
	logic [AW-1:0]                ram_raddr;
	logic [sle_pkg::ValW-1:0]     ram_wdata;
	logic [sle_pkg::ValW-1:0]     ram_rdata;

	assign in_stall  = busy_q;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign pos_k    = KW'(pos_q);
	assign in_pos_k = KW'(in_data.position);
	assign cnt_k    = KW'(cnt_q);
	assign idx_k    = KW'(idx_q);
	assign hi_k     = KW'(hi_q);
	assign limit_k  = KW'(limit_q);
	assign lim_k    = (limit_k > CAP_K) ? CAP_K : limit_k;

	assign uw       = sle_pkg::ucode(pc_q);
	assign out_free = !out_valid_q || !out_stall;
	assign step_go  = busy_q && (!uw.fin || out_free);

	always_comb begin
		entry_pc = sle_pkg::ST_FIN;
		entry_ok = 1'b0;
		case (in_data.op)
			sle_pkg::OP_CLEAR: begin
				entry_pc = sle_pkg::ST_CLR;
				entry_ok = 1'b1;
			end
			sle_pkg::OP_INSERT: begin
				if (in_pos_k < lim_k && in_data.value != '0 && cnt_k < lim_k) begin
					entry_ok = 1'b1;
					entry_pc = (in_pos_k < cnt_k) ? sle_pkg::ST_INS0 : sle_pkg::ST_APP;
				end
			end
			sle_pkg::OP_DELETE: begin
				if (in_pos_k < cnt_k) begin
					entry_ok = 1'b1;
					entry_pc = sle_pkg::ST_DEL0;
				end
			end
			sle_pkg::OP_READ: begin
				if (in_pos_k < lim_k) begin
					entry_ok = 1'b1;
					if (in_pos_k < cnt_k) begin
						entry_pc = sle_pkg::ST_RD0;
					end
				end
			end
			sle_pkg::OP_REVERSE: begin
				entry_ok = 1'b1;
				if (cnt_k > KW'(1)) begin
					entry_pc = sle_pkg::ST_REV0;
				end
			end
			default: begin
				entry_ok = 1'b0;
			end
		endcase
	end

	always_comb begin
		case (uw.jc)
			sle_pkg::JC_INS_MORE: jump = idx_k > pos_k + KW'(1);
			sle_pkg::JC_DEL_END:  jump = pos_k + KW'(1) >= cnt_k;
			sle_pkg::JC_DEL_MORE: jump = idx_k + KW'(2) < cnt_k;
			sle_pkg::JC_REV_MORE: jump = idx_k + KW'(2) < hi_k;
			default:              jump = 1'b0;
		endcase
		pc_next = jump ? uw.tgt : pc_q + 1'b1;
	end

	always_comb begin
		case (uw.cnt_op)
			sle_pkg::CN_CLR: cnt_next = '0;
			sle_pkg::CN_INC: cnt_next = cnt_q + 1'b1;
			sle_pkg::CN_DEC: cnt_next = cnt_q - 1'b1;
			default:         cnt_next = cnt_q;
		endcase
	end

	always_comb begin
		case (uw.rd_sel)
			sle_pkg::RD_IDX_M1: ram_raddr = idx_q - 1'b1;
			sle_pkg::RD_IDX_P1: ram_raddr = idx_q + 1'b1;
			sle_pkg::RD_HI:     ram_raddr = hi_q;
			sle_pkg::RD_POS:    ram_raddr = AW'(pos_q);
			default:            ram_raddr = idx_q;
		endcase
		case (uw.wa_sel)
			sle_pkg::WA_HI:  ram_waddr = hi_q;
			sle_pkg::WA_CNT: ram_waddr = AW'(cnt_q);
			default:         ram_waddr = idx_q;
		endcase
		case (uw.wd_sel)
			sle_pkg::WD_TMP: ram_wdata = tmp_q;
			sle_pkg::WD_VAL: ram_wdata = val_q;
			default:         ram_wdata = ram_rdata;
		endcase
	end

	assign ram_we = step_go && uw.wr_en;
	assign ram_re = step_go && (uw.rd_sel != sle_pkg::RD_NONE);

	sle_ram #(
		.WIDTH (sle_pkg::ValW),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			pc_q        <= sle_pkg::ST_FIN;
			cnt_q       <= '0;
			limit_q     <= sle_pkg::LIMIT_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				limit_q <= cfg_data;
			end
			if (in_valid && !busy_q) begin
				busy_q <= 1'b1;
				pc_q   <= entry_pc;
			end else if (step_go) begin
				pc_q  <= pc_next;
				cnt_q <= cnt_next;
				if (uw.fin) begin
					busy_q <= 1'b0;
				end
			end
			if (step_go && uw.fin) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !busy_q) begin
			pos_q <= in_data.position;
			val_q <= in_data.value;
			ok_q  <= entry_ok;
		end
		if (step_go) begin
			case (uw.idx_op)
				sle_pkg::IX_CNT:  idx_q <= AW'(cnt_q);
				sle_pkg::IX_POS:  idx_q <= AW'(pos_q);
				sle_pkg::IX_ZERO: idx_q <= '0;
				sle_pkg::IX_INC:  idx_q <= idx_q + 1'b1;
				sle_pkg::IX_DEC:  idx_q <= idx_q - 1'b1;
				default:          idx_q <= idx_q;
			endcase
			case (uw.hi_op)
				sle_pkg::HI_CNTM1: hi_q <= AW'(cnt_q - 1'b1);
				sle_pkg::HI_DEC:   hi_q <= hi_q - 1'b1;
				default:           hi_q <= hi_q;
			endcase
			if (uw.tmp_ld) begin
				tmp_q <= ram_rdata;
			end
			if (uw.fin) begin
				out_q.ok         <= ok_q;
				out_q.read_value <= uw.rd_cap ? ram_rdata : '0;
				out_q.count      <= sle_pkg::CntOutW'(cnt_next);
			end
		end
	end

	`SLE_AST_IMPL(a_cnt_cap, 1'b1, cnt_k <= CAP_K)
	`SLE_AST_IMPL(a_we_busy, ram_we, busy_q)
	`SLE_AST_IMPL(a_wr_range, ram_we, KW'(ram_waddr) <= cnt_k)
	`SLE_AST_NEXT(a_fin_done, step_go && uw.fin, !busy_q && out_valid_q)

endmodule

`default_nettype wire

[verif/sle_list_checker.sv]
// Checker for the list engine: watches the channels, predicts each result and compares it
`timescale 1ns / 100ps

module sle_list_checker #(
	parameter int LIST_DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	input  logic                     in_stall,
	input  sle_pkg::in_item_t        in_data,
	input  logic                     out_valid,
	input  logic                     out_stall,
	input  sle_pkg::out_item_t       out_data,
	input  logic                     cfg_valid,
	input  logic                     cfg_ready,
	input  logic [sle_pkg::LimW-1:0] cfg_data,
	output int                       error_count,
	output int                       pending_results
);

	import sle_pkg::*;

	logic [ValW-1:0]  list_words [LIST_DEPTH];
	int               list_len;
	logic [LimW-1:0]  limit_setting;
	out_item_t        expected_results [$];

	function automatic out_item_t run_command(input in_item_t c);
		out_item_t       r;
		int              lim;
		int              i;
		int              lo;
		int              hi;
		logic [ValW-1:0] t;
		lim = (limit_setting > LIST_DEPTH) ? LIST_DEPTH : int'(limit_setting);
		r = '0;
		case (c.op)
			OP_CLEAR: begin
				for (i = 0; i < LIST_DEPTH; i++)
					list_words[i] = '0;
				list_len = 0;
				r.ok = 1'b1;
			end
			OP_INSERT: begin
				if (c.position < lim && c.value != '0 && list_len < lim) begin
					if (c.position < list_len) begin
						for (i = list_len; i > c.position; i--)
							list_words[i] = list_words[i-1];
						list_words[c.position] = c.value;
					end else begin
						list_words[list_len] = c.value;
					end
					list_len++;
					r.ok = 1'b1;
				end
			end
			OP_DELETE: begin
				if (c.position < list_len) begin
					for (i = c.position; i + 1 < list_len; i++)
						list_words[i] = list_words[i+1];
					list_len--;
					list_words[list_len] = '0;
					r.ok = 1'b1;
				end
			end
			OP_READ: begin
				if (c.position < lim) begin
					r.read_value = list_words[c.position];
					r.ok = 1'b1;
				end
			end
			OP_REVERSE: begin
				lo = 0;
				hi = list_len - 1;
				while (lo < hi) begin
					t = list_words[lo];
					list_words[lo] = list_words[hi];
					list_words[hi] = t;
					lo++;
					hi--;
				end
				r.ok = 1'b1;
			end
			default: begin
			end
		endcase
		r.count = CntOutW'(list_len);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_item_t exp_item;
		if (!arst_n) begin
			for (int k = 0; k < LIST_DEPTH; k++)
				list_words[k] = '0;
			list_len = 0;
			limit_setting = LIMIT_RESET;
			expected_results.delete();
			error_count = 0;
			pending_results = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				limit_setting = cfg_data;
			if (in_valid && !in_stall)
				expected_results.push_back(run_command(in_data));
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					$error("unexpected result transfer: ok %0d read_value %0h count %0d",
						out_data.ok, out_data.read_value, out_data.count);
					error_count++;
				end else begin
					exp_item = expected_results.pop_front();
					if (out_data.ok !== exp_item.ok) begin
						$error("ok mismatch: expected %0d, actual %0d",
							exp_item.ok, out_data.ok);
						error_count++;
					end
					if (out_data.read_value !== exp_item.read_value) begin
						$error("read_value mismatch: expected %0h, actual %0h",
							exp_item.read_value, out_data.read_value);
						error_count++;
					end
					if (out_data.count !== exp_item.count) begin
						$error("count mismatch: expected %0d, actual %0d",
							exp_item.count, out_data.count);
						error_count++;
					end
				end
			end
			pending_results = expected_results.size();
		end
	end

endmodule

[verif/tb_sequential_list_engine_top.sv]
// Testbench top for the list engine: clock, reset, stimulus and verdict
`timescale 1ns / 100ps

module tb_sequential_list_engine_top;

	import sle_pkg::*;

	localparam int LIST_DEPTH = 1024;
	localparam int HOLD_CYCLES = 300;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	in_item_t          in_data;
	logic              out_valid;
	logic              out_stall;
	out_item_t         out_data;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [LimW-1:0]   cfg_data;
	int                error_count;
	int                pending_results;
	int                snd_idle = 0;
	int                rcv_idle = 0;
	int                hold_requests = 0;
	int                hold_served;
	int                hold_left;
	int                cur_limit = LIST_DEPTH;

	sequential_list_engine_top #(
		.CAPACITY (LIST_DEPTH)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	sle_list_checker #(
		.LIST_DEPTH (LIST_DEPTH)
	) u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.in_data         (in_data),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.out_data        (out_data),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_data        (cfg_data),
		.error_count     (error_count),
		.pending_results (pending_results)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// hold off the result side for a long stretch on request
	initial begin
		out_stall = 1'b0;
		hold_served = 0;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_left == 0 && hold_served != hold_requests) begin
				hold_served++;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= ($urandom_range(99) < rcv_idle);
			end
		end
	end

	initial begin
		#20_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	task automatic push_cmd(input in_item_t c);
		while ($urandom_range(99) < snd_idle) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= c;
		do
			@(posedge clk);
		while (in_stall);
		@(negedge clk);
	endtask

	task automatic push_fields(input logic [OpW-1:0] op, input int pos,
		input logic [ValW-1:0] val);
		in_item_t c;
		c.op = op;
		c.position = PosW'(pos);
		c.value = val;
		push_cmd(c);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending_results != 0)
			@(negedge clk);
	endtask

	task automatic write_limit(input logic [LimW-1:0] v);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		cur_limit = v;
	endtask

	function automatic in_item_t make_command();
		in_item_t    c;
		int          roll;
		int          span;
		int          lim;
		logic [31:0] rnd;
		lim = (cur_limit > LIST_DEPTH) ? LIST_DEPTH : cur_limit;
		span = (lim > 48) ? 48 : lim + 1;
		roll = $urandom_range(99);
		if (roll < 3)
			c.op = OP_CLEAR;
		else if (roll < 45)
			c.op = OP_INSERT;
		else if (roll < 65)
			c.op = OP_DELETE;
		else if (roll < 87)
			c.op = OP_READ;
		else if (roll < 96)
			c.op = OP_REVERSE;
		else
			c.op = OpW'($urandom_range(int'(OP_REVERSE) + 1, (1 << OpW) - 1));
		if ($urandom_range(9) == 0)
			c.position = PosW'($urandom);
		else
			c.position = PosW'($urandom_range(span));
		rnd = $urandom;
		case ($urandom_range(19))
			0:       c.value = '0;
			1:       c.value = '1;
			2:       c.value = ValW'(1);
			default: c.value = rnd[ValW-1:0];
		endcase
		return c;
	endfunction

	task automatic run_random(input int n, input int snd, input int rcv,
		input int hold_at, input int pause_at);
		snd_idle = snd;
		rcv_idle = rcv;
		for (int k = 0; k < n; k++) begin
			if (k == hold_at)
				hold_requests++;
			if (k == pause_at)
				drain();
			push_cmd(make_command());
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		snd_idle = 38;
		rcv_idle = 77;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty list at the reset limit
		push_fields(OP_READ, 0, '0);
		push_fields(OP_READ, 1023, '1);
		push_fields(OP_DELETE, 0, '0);
		push_fields(OP_REVERSE, 0, '0);
		push_fields(OP_INSERT, 0, '0);
		push_fields(OP_INSERT, 0, 31'h7FFF_FFFF);
		push_fields(OP_INSERT, 1023, 31'h0000_0001);
		push_fields(OP_INSERT, 0, 31'h2AAA_AAAA);
		push_fields(OP_INSERT, 1, 31'h5555_5555);
		push_fields(OP_REVERSE, 0, '0);
		push_fields(OP_READ, 3, '0);
		push_fields(OP_READ, 4, '0);
		push_fields(OP_DELETE, 3, '0);
		push_fields(OP_DELETE, 3, '0);
		push_fields(OpW'(int'(OP_REVERSE) + 1), 1, 31'h1234_5678);
		push_fields(OpW'((1 << OpW) - 1), 1023, '1);
		push_fields(OP_CLEAR, 0, '0);
		push_fields(OP_READ, 0, '0);

		// lower the limit below the count
		write_limit(LimW'(4));
		for (int k = 0; k < 4; k++)
			push_fields(OP_INSERT, 0, ValW'(k + 10));
		write_limit(LimW'(2));
		push_fields(OP_INSERT, 1, ValW'(99));
		push_fields(OP_READ, 1, '0);
		push_fields(OP_READ, 2, '0);
		push_fields(OP_REVERSE, 0, '0);
		push_fields(OP_DELETE, 3, '0);
		write_limit('0);
		push_fields(OP_READ, 0, '0);
		push_fields(OP_INSERT, 0, ValW'(5));
		push_fields(OP_DELETE, 0, '0);
		push_fields(OP_REVERSE, 0, '0);

		write_limit(LimW'(1));
		run_random(40, 38, 77, -1, -1);
		write_limit(LimW'(8));
		run_random(120, 38, 77, 60, -1);
		write_limit(LimW'(LIST_DEPTH));
		run_random(120, 77, 38, -1, -1);
		write_limit('1);
		run_random(60, 77, 38, -1, -1);
		write_limit(LimW'(16));
		run_random(120, 0, 0, -1, 60);
		write_limit('0);
		run_random(20, 0, 0, -1, -1);
		write_limit(LIMIT_RESET);
		run_random(100, 0, 0, 50, -1);

		drain();
		repeat (20) @(negedge clk);
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
